// ===== design/generational_handle_allocator_defines.svh =====
// Assertion macros used by the checker file.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_DEFINES_SVH

// cond in this cycle implies chk in this cycle
`define GHA_ASSERT_NOW(label, clk, rst_n, cond, chk, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (chk)) \
        else $error(msg);

// cond in this cycle implies chk in the next cycle
`define GHA_ASSERT_NEXT(label, clk, rst_n, cond, chk, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (chk)) \
        else $error(msg);

`endif

// ===== design/gha_pkg.sv =====
package gha_pkg;

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_DESTROY = 3'd1,
        OP_QUERY   = 3'd2,
        OP_LOCK    = 3'd3,
        OP_UNLOCK  = 3'd4,
        OP_CLEAR   = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_CREATED = 2'd0,
        KIND_ALIVE   = 2'd1,
        KIND_REMOVED = 2'd2,
        KIND_DROPPED = 2'd3
    } kind_t;

    // one-hot sequencer state
    typedef enum logic [1:0] {
        S_RUN   = 2'b01,
        S_DRAIN = 2'b10
    } state_t;

endpackage

// ===== design/gha_channels.sv =====
// Command channel
interface gha_req_if #(
    parameter int ID_BITS  = 10,
    parameter int GEN_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [2:0]          opcode;
    logic [ID_BITS-1:0]  entity_id;
    logic [GEN_BITS-1:0] entity_generation;

    modport source (output valid, output opcode, output entity_id,
                    output entity_generation, input ready);
    modport sink   (input valid, input opcode, input entity_id,
                    input entity_generation, output ready);
endinterface

// Result channel
interface gha_rsp_if #(
    parameter int ID_BITS  = 10,
    parameter int GEN_BITS = 16
);
    logic                valid;
    logic                ready;
    logic [1:0]          result_kind;
    logic [ID_BITS-1:0]  result_id;
    logic [GEN_BITS-1:0] result_generation;
    logic                alive;
    logic                last;

    modport source (output valid, output result_kind, output result_id,
                    output result_generation, output alive, output last,
                    input ready);
    modport sink   (input valid, input result_kind, input result_id,
                    input result_generation, input alive, input last,
                    output ready);
endinterface

// ===== design/gha_gen_store.sv =====
// Generation table: one write and one registered read per cycle.
// Same-address write and read in one cycle forward the written value.
module gha_gen_store #(
    parameter int ID_BITS  = 10,
    parameter int GEN_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rd_en,
    input  logic [ID_BITS-1:0]  rd_addr,
    input  logic                wr_en,
    input  logic [ID_BITS-1:0]  wr_addr,
    input  logic [GEN_BITS-1:0] wr_data,
    output logic [GEN_BITS-1:0] rd_data
);
    localparam int DEPTH = 1 << ID_BITS;

    logic [GEN_BITS-1:0] mem [DEPTH];
    logic [GEN_BITS-1:0] mem_rd_reg;
    logic [GEN_BITS-1:0] fwd_data_reg;
    logic                fwd_hit_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rd_reg   <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_hit_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_hit_reg ? fwd_data_reg : mem_rd_reg;
endmodule

// ===== design/gha_removal_queue.sv =====
// Pending removal store: handles kept in arrival order, registered read.
module gha_removal_queue #(
    parameter int ID_BITS     = 10,
    parameter int GEN_BITS    = 16,
    parameter int QUEUE_DEPTH = 32,
    localparam int QA_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [QA_W-1:0]     wr_addr,
    input  logic [ID_BITS-1:0]  wr_id,
    input  logic [GEN_BITS-1:0] wr_gen,
    input  logic                rd_en,
    input  logic [QA_W-1:0]     rd_addr,
    output logic [ID_BITS-1:0]  rd_id,
    output logic [GEN_BITS-1:0] rd_gen
);
    localparam int ENTRY_W = ID_BITS + GEN_BITS;

    logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_id, wr_gen};
        end
        if (rd_en)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    assign rd_id  = rd_reg[ENTRY_W-1:GEN_BITS];
    assign rd_gen = rd_reg[GEN_BITS-1:0];
endmodule

// ===== design/generational_handle_allocator.sv =====
// Channel | Modport | Beat carries
// --------+---------+-----------------------------------------------------
// req     | sink    | opcode, entity_id, entity_generation
// rsp     | source  | result_kind, result_id, result_generation, alive, last
//
// Create, destroy and query run at one beat per cycle unless rsp stalls: the
// command is taken, its table read registered, and the execute stage modifies
// and writes back, with a same-address write forwarded into the following
// read. A final unlock with N queued handles streams N removal beats from the
// queue's read port, one per cycle unless rsp stalls, holding req.ready low.
// A result waits in the output register; a stalled rsp holds result ops in
// execute. Reset (rst_n, async) clears counters and control only; no sweep.
module generational_handle_allocator #(
    parameter int ID_BITS     = 10,
    parameter int GEN_BITS    = 16,
    parameter int QUEUE_DEPTH = 32,
    parameter int LOCK_BITS   = 8
) (
    input logic  clk,
    input logic  rst_n,
    gha_req_if.sink   req,
    gha_rsp_if.source rsp
);
    import gha_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int QA_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [ID_BITS-1:0]   ID_INVALID = '1;
    localparam logic [LOCK_BITS-1:0] LOCK_MAX   = '1;
    localparam logic [CNT_W-1:0]     QUEUE_FULL = CNT_W'(QUEUE_DEPTH);

    // sequencer and architectural counters
    state_t               state_reg;
    logic [ID_BITS-1:0]   next_id_reg, next_id_next;
    logic [LOCK_BITS-1:0] lock_reg, lock_next;
    logic [CNT_W-1:0]     count_reg, count_next;

    // execute stage
    logic                 ex_valid_reg;
    logic [2:0]           ex_op_reg;
    logic [ID_BITS-1:0]   ex_id_reg;
    logic [GEN_BITS-1:0]  ex_gen_reg;

    // drain pointers
    logic [CNT_W-1:0]     issue_reg;
    logic [CNT_W-1:0]     emit_reg;
    logic                 qv_reg;

    // output register
    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic [ID_BITS-1:0]   out_id_reg;
    logic [GEN_BITS-1:0]  out_gen_reg;
    logic                 out_alive_reg;
    logic                 out_last_reg;

    logic                 accept;
    logic                 out_free;
    logic                 ex_fire;
    logic                 ex_result;
    logic                 ex_wr;
    logic                 ex_push;
    logic                 drain_start;
    logic [ID_BITS-1:0]   ex_waddr;
    logic [GEN_BITS-1:0]  ex_wdata;
    kind_t                res_kind;
    logic [ID_BITS-1:0]   res_id;
    logic [GEN_BITS-1:0]  res_gen;
    logic                 res_alive;
    logic                 issued;

    logic [GEN_BITS-1:0]  stored_gen;
    logic                 q_rd_en;
    logic [ID_BITS-1:0]   q_rd_id;
    logic [GEN_BITS-1:0]  q_rd_gen;
    logic                 consume;
    logic                 drain_last;

    gha_gen_store #(
        .ID_BITS  (ID_BITS),
        .GEN_BITS (GEN_BITS)
    ) u_gen_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (req.entity_id),
        .wr_en   (ex_fire && ex_wr),
        .wr_addr (ex_waddr),
        .wr_data (ex_wdata),
        .rd_data (stored_gen)
    );

    gha_removal_queue #(
        .ID_BITS     (ID_BITS),
        .GEN_BITS    (GEN_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .wr_en   (ex_fire && ex_push),
        .wr_addr (count_reg[QA_W-1:0]),
        .wr_id   (ex_id_reg),
        .wr_gen  (ex_gen_reg),
        .rd_en   (q_rd_en),
        .rd_addr (issue_reg[QA_W-1:0]),
        .rd_id   (q_rd_id),
        .rd_gen  (q_rd_gen)
    );

    assign out_free = !out_valid_reg || rsp.ready;
    assign issued   = ex_id_reg < next_id_reg;

    // execute: decode the held command against the table read
    always_comb
    begin
        ex_result    = 1'b0;
        ex_wr        = 1'b0;
        ex_push      = 1'b0;
        drain_start  = 1'b0;
        ex_waddr     = ex_id_reg;
        ex_wdata     = stored_gen + GEN_BITS'(1);
        res_kind     = KIND_REMOVED;
        res_id       = ex_id_reg;
        res_gen      = ex_gen_reg;
        res_alive    = 1'b0;
        next_id_next = next_id_reg;
        lock_next    = lock_reg;
        count_next   = count_reg;
        case (ex_op_reg)
            OP_CREATE:
            begin
                ex_result = 1'b1;
                res_kind  = KIND_CREATED;
                res_gen   = '0;
                if (next_id_reg == ID_INVALID)
                begin
                    res_id = ID_INVALID;
                end
                else
                begin
                    res_id       = next_id_reg;
                    ex_wr        = 1'b1;
                    ex_waddr     = next_id_reg;
                    ex_wdata     = '0;
                    next_id_next = next_id_reg + ID_BITS'(1);
                end
            end
            OP_DESTROY:
            begin
                ex_wr = issued;
                if (lock_reg == '0)
                begin
                    ex_result = 1'b1;
                end
                else if (count_reg >= QUEUE_FULL)
                begin
                    ex_result = 1'b1;
                    res_kind  = KIND_DROPPED;
                end
                else
                begin
                    ex_push    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_QUERY:
            begin
                ex_result = 1'b1;
                res_kind  = KIND_ALIVE;
                res_id    = '0;
                res_gen   = '0;
                res_alive = issued && (stored_gen == ex_gen_reg);
            end
            OP_LOCK:
            begin
                if (lock_reg != LOCK_MAX)
                begin
                    lock_next = lock_reg + LOCK_BITS'(1);
                end
            end
            OP_UNLOCK:
            begin
                if (lock_reg != '0)
                begin
                    lock_next   = lock_reg - LOCK_BITS'(1);
                    drain_start = (lock_reg == LOCK_BITS'(1)) && (count_reg != '0);
                end
            end
            OP_CLEAR:
            begin
                next_id_next = '0;
                lock_next    = '0;
                count_next   = '0;
            end
            default:
            begin
                ex_result = 1'b0;
            end
        endcase
    end

    assign ex_fire   = ex_valid_reg && (state_reg == S_RUN) && (!ex_result || out_free);
    assign req.ready = (state_reg == S_RUN) && (!ex_valid_reg || (ex_fire && !drain_start));
    assign accept    = req.valid && req.ready;

    // drain: one queue read in flight, refilled as each beat leaves
    assign consume    = (state_reg == S_DRAIN) && qv_reg && out_free;
    assign q_rd_en    = (state_reg == S_DRAIN) && (issue_reg != count_reg)
                        && (!qv_reg || consume);
    assign drain_last = emit_reg == (count_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            next_id_reg   <= '0;
            lock_reg      <= '0;
            count_reg     <= '0;
            ex_valid_reg  <= 1'b0;
            issue_reg     <= '0;
            emit_reg      <= '0;
            qv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                ex_valid_reg <= 1'b1;
            end
            else if (ex_fire)
            begin
                ex_valid_reg <= 1'b0;
            end

            if (ex_fire)
            begin
                next_id_reg <= next_id_next;
                lock_reg    <= lock_next;
                count_reg   <= count_next;
                if (drain_start)
                begin
                    state_reg <= S_DRAIN;
                    issue_reg <= '0;
                    emit_reg  <= '0;
                    qv_reg    <= 1'b0;
                end
            end

            if (q_rd_en)
            begin
                issue_reg <= issue_reg + CNT_W'(1);
                qv_reg    <= 1'b1;
            end
            else if (consume)
            begin
                qv_reg <= 1'b0;
            end

            if (consume)
            begin
                emit_reg <= emit_reg + CNT_W'(1);
                if (drain_last)
                begin
                    state_reg <= S_RUN;
                    count_reg <= '0;
                end
            end

            if ((ex_fire && ex_result) || consume)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge clk)
    begin
        if (ex_fire && ex_result)
        begin
            out_kind_reg  <= res_kind;
            out_id_reg    <= res_id;
            out_gen_reg   <= res_gen;
            out_alive_reg <= res_alive;
            out_last_reg  <= 1'b1;
        end
        else if (consume)
        begin
            out_kind_reg  <= KIND_REMOVED;
            out_id_reg    <= q_rd_id;
            out_gen_reg   <= q_rd_gen;
            out_alive_reg <= 1'b0;
            out_last_reg  <= drain_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ex_op_reg  <= req.opcode;
            ex_id_reg  <= req.entity_id;
            ex_gen_reg <= req.entity_generation;
        end
    end

    assign rsp.valid             = out_valid_reg;
    assign rsp.result_kind       = out_kind_reg;
    assign rsp.result_id         = out_id_reg;
    assign rsp.result_generation = out_gen_reg;
    assign rsp.alive             = out_alive_reg;
    assign rsp.last              = out_last_reg;
endmodule

// ===== design/gha_checker.sv =====
`include "generational_handle_allocator_defines.svh"

module gha_checker #(
    parameter int ID_BITS  = 10,
    parameter int GEN_BITS = 16
) (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [1:0]          rsp_kind,
    input logic [ID_BITS-1:0]  rsp_id,
    input logic [GEN_BITS-1:0] rsp_gen,
    input logic                rsp_alive,
    input logic                rsp_last
);
    import gha_pkg::*;

    // stalled beat holds
    `GHA_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_id) && $stable(rsp_gen) && $stable(rsp_kind) && $stable(rsp_last), "gha: stalled result changed")

    // query answers carry no handle
    `GHA_ASSERT_NOW(a_alive_no_handle, clk, rst_n, rsp_valid && (rsp_kind == KIND_ALIVE), (rsp_id == '0) && (rsp_gen == '0) && rsp_last, "gha: query result carries a handle")

    // only query answers may flag alive
    `GHA_ASSERT_NOW(a_alive_only_query, clk, rst_n, rsp_valid && (rsp_kind != KIND_ALIVE), !rsp_alive, "gha: alive set on non-query result")

    // created and dropped beats stand alone
    `GHA_ASSERT_NOW(a_single_last, clk, rst_n, rsp_valid && ((rsp_kind == KIND_CREATED) || (rsp_kind == KIND_DROPPED)), rsp_last, "gha: single result without last")
endmodule

bind generational_handle_allocator gha_checker #(
    .ID_BITS  (ID_BITS),
    .GEN_BITS (GEN_BITS)
) u_gha_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_kind  (rsp.result_kind),
    .rsp_id    (rsp.result_id),
    .rsp_gen   (rsp.result_generation),
    .rsp_alive (rsp.alive),
    .rsp_last  (rsp.last)
);
